[rtl/core/sspc_pkg.sv]
// Package: shared constants, codes and sequencer states for the spindle speed controller.
`default_nettype none
package sspc_pkg;

    localparam int RPM_W   = 20;
    localparam int SLOPE_W = 32;
    localparam int OVR_W   = 8;
    localparam int RAW_W   = 7;
    localparam int FLD_W   = 7;   // duty / compare level field width
    localparam int PWM_W   = 8;   // internal pwm width, holds any period up to 255
    localparam int KIND_W  = 2;
    localparam int DIR_W   = 2;
    localparam int CIDX_W  = 3;
    localparam int CDAT_W  = 32;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 64;
    localparam int SCALED_W = 22;

    localparam logic [PWM_W-1:0] PWM_PERIOD    = 8'd100;
    localparam logic [PWM_W-1:0] PWM_MAX_VALUE = 8'd100;
    localparam logic [PWM_W-1:0] PWM_MIN_VALUE = 8'd1;
    localparam logic [PWM_W-1:0] PWM_OFF_VALUE = 8'd0;

    // floor(x / 100) = (x * ceil(2^35 / 100)) >> 35, exact for x < 2^30
    localparam logic [MUL_W-1:0] RECIP_100 = 32'd343597384;
    localparam int RECIP_SHIFT = 35;
    localparam int SLOPE_SHIFT = 28;

    localparam logic [RPM_W-1:0]   RPM_MAX_RESET = 20'd16000;
    localparam logic [SLOPE_W-1:0] SLOPE_RESET   = 32'd1677722;

    localparam logic [KIND_W-1:0] KIND_SET     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RAW     = 2'd2;

    localparam logic [DIR_W-1:0] DIR_OFF = 2'd0;
    localparam logic [DIR_W-1:0] DIR_CW  = 2'd1;

    localparam logic [CIDX_W-1:0] CFG_RPM_MIN   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_RPM_MAX   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_SLOPE     = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_LASER     = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_OFF_ZERO  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_INVERT_EN = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_MUL_C,
        S_APPLY
    } seq_state_t;

endpackage
`default_nettype wire

[rtl/core/spindle_speed_pwm_control.sv]
// Top level: spindle rpm to PWM mapping with pin and timer state, one shared multiplier.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+---------------------------------------------
//  s_       | in  | s_tvalid / s_tready  | s_tuser kind, s_tdata command fields
//  m_       | out | m_tvalid / m_tready  | m_tdata result fields
//  cfg_     | in  | cfg_valid / cfg_ready| cfg_index register, cfg_data value
//
// After acceptance the result is formed by three passes through the shared
// 32x32 multiplier (override, divide by 100, slope) and the apply state.
// A new transaction is taken in the cycle after the result is loaded, not before.
// aresetn clears the sequencer, spindle state and configuration to their reset values.
// The apply cycle holds while a previous result still waits on m_tready.
`default_nettype none
module spindle_speed_pwm_control (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [1:0] direction_request, [21:2] requested_rpm, [29:22] override_percent,
    // [36:30] raw_pwm, [37] blocked, [39:38] zero
    input  wire logic [sspc_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] kind
    input  wire logic [sspc_pkg::KIND_W-1:0]   s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [6:0] duty, [13:7] compare_level, [14] timer_running, [15] enable_pin,
    // [16] direction_pin, [17] spindle_on, [37:18] effective_speed, [38] report_now,
    // [39] zero
    output logic [sspc_pkg::M_DATA_W-1:0]      m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sspc_pkg::CIDX_W-1:0]   cfg_index,
    input  wire logic [sspc_pkg::CDAT_W-1:0]   cfg_data
);

    localparam int RPM_W   = sspc_pkg::RPM_W;
    localparam int PWM_W   = sspc_pkg::PWM_W;
    localparam int FLD_W   = sspc_pkg::FLD_W;
    localparam int MUL_W   = sspc_pkg::MUL_W;
    localparam int PROD_W  = sspc_pkg::PROD_W;
    localparam int SC_W    = sspc_pkg::SCALED_W;
    localparam int RS      = sspc_pkg::RECIP_SHIFT;
    localparam int SS      = sspc_pkg::SLOPE_SHIFT;
    localparam int SUM_W   = PROD_W - SS + 1;

    // configuration
    logic [RPM_W-1:0]            rpm_min_reg;
    logic [RPM_W-1:0]            rpm_max_reg;
    logic [sspc_pkg::SLOPE_W-1:0] slope_reg;
    logic                        laser_reg;
    logic                        off_zero_reg;
    logic                        invert_en_reg;

    // latched command
    logic [sspc_pkg::KIND_W-1:0] kind_reg;
    logic [sspc_pkg::DIR_W-1:0]  dir_reg;
    logic [RPM_W-1:0]            rpm_reg;
    logic [sspc_pkg::OVR_W-1:0]  ovr_reg;
    logic [sspc_pkg::RAW_W-1:0]  raw_reg;
    logic                        blocked_reg;

    // datapath
    logic [PROD_W-1:0] prod_reg;
    logic [SC_W-1:0]   scaled_reg;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic              load_prod;
    logic              load_scaled;
    logic              apply_en;

    // spindle state
    logic [PWM_W-1:0] compare_reg, compare_next;
    logic             timer_reg, timer_next;
    logic             enable_reg, enable_next;
    logic             dir_lvl_reg, dir_lvl_next;
    logic             running_reg, running_next;
    logic [RPM_W-1:0] speed_reg, speed_next;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic [sspc_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    sspc_pkg::seq_state_t state_reg, state_next;

    logic                    s_hs;
    logic                    laser_zero;
    logic [PWM_W-1:0]        map_pwm;
    logic [RPM_W-1:0]        map_speed;
    logic [SUM_W-1:0]        pwm_sum;
    logic [PWM_W-1:0]        raw_sat;
    logic [PWM_W-1:0]        pwm_out;
    logic                    report;

    assign s_hs      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // laser mode zeroes counterclockwise set-state requests
    assign laser_zero = laser_reg && (s_tuser == sspc_pkg::KIND_SET) &&
                        (s_tdata[1:0] != sspc_pkg::DIR_OFF) &&
                        (s_tdata[1:0] != sspc_pkg::DIR_CW);

    // sequencer: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sspc_pkg::S_IDLE:  if (s_tvalid) state_next = sspc_pkg::S_MUL_A;
            sspc_pkg::S_MUL_A: state_next = sspc_pkg::S_MUL_B;
            sspc_pkg::S_MUL_B: state_next = sspc_pkg::S_MUL_C;
            sspc_pkg::S_MUL_C: state_next = sspc_pkg::S_APPLY;
            sspc_pkg::S_APPLY: if (!m_tvalid_reg || m_tready) state_next = sspc_pkg::S_IDLE;
            default:           state_next = sspc_pkg::S_IDLE;
        endcase
    end

    // sequencer: outputs and multiplier operand select
    always_comb begin
        s_tready    = 1'b0;
        load_prod   = 1'b0;
        load_scaled = 1'b0;
        apply_en    = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        case (state_reg)
            sspc_pkg::S_IDLE: begin
                s_tready = 1'b1;
            end
            sspc_pkg::S_MUL_A: begin
                load_prod = 1'b1;
                mul_a     = MUL_W'(rpm_reg);
                mul_b     = MUL_W'(ovr_reg);
            end
            sspc_pkg::S_MUL_B: begin
                load_prod   = 1'b1;
                load_scaled = 1'b0;
                mul_a       = MUL_W'(prod_reg[27:0]);
                mul_b       = sspc_pkg::RECIP_100;
            end
            sspc_pkg::S_MUL_C: begin
                load_prod   = 1'b1;
                load_scaled = 1'b1;
                mul_a       = MUL_W'(prod_reg[RS+SC_W-1:RS] - SC_W'(rpm_min_reg));
                mul_b       = slope_reg;
            end
            sspc_pkg::S_APPLY: begin
                apply_en = !m_tvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // speed mapping from the scaled rpm and the slope product
    always_comb begin
        pwm_sum = SUM_W'(prod_reg[PROD_W-1:SS]) + SUM_W'(sspc_pkg::PWM_MIN_VALUE);
        if ((rpm_min_reg >= rpm_max_reg) || (scaled_reg >= SC_W'(rpm_max_reg))) begin
            map_speed = rpm_max_reg;
            map_pwm   = sspc_pkg::PWM_MAX_VALUE;
        end else if (scaled_reg <= SC_W'(rpm_min_reg)) begin
            if (scaled_reg == '0) begin
                map_speed = '0;
                map_pwm   = sspc_pkg::PWM_OFF_VALUE;
            end else begin
                map_speed = rpm_min_reg;
                map_pwm   = sspc_pkg::PWM_MIN_VALUE;
            end
        end else begin
            map_speed = scaled_reg[RPM_W-1:0];
            if (pwm_sum > SUM_W'(sspc_pkg::PWM_MAX_VALUE)) begin
                map_pwm = sspc_pkg::PWM_MAX_VALUE;
            end else begin
                map_pwm = pwm_sum[PWM_W-1:0];
            end
        end
    end

    assign raw_sat = (PWM_W'(raw_reg) > sspc_pkg::PWM_PERIOD) ? sspc_pkg::PWM_PERIOD
                                                               : PWM_W'(raw_reg);

    // state update for the command
    always_comb begin
        compare_next = compare_reg;
        timer_next   = timer_reg;
        enable_next  = enable_reg;
        dir_lvl_next = dir_lvl_reg;
        running_next = running_reg;
        speed_next   = speed_reg;
        pwm_out      = '0;
        report       = 1'b0;
        case (kind_reg)
            sspc_pkg::KIND_SET: begin
                if (!blocked_reg) begin
                    report = 1'b1;
                    if (dir_reg == sspc_pkg::DIR_OFF) begin
                        speed_next   = '0;
                        compare_next = sspc_pkg::PWM_PERIOD;
                        running_next = 1'b0;
                        enable_next  = 1'b0;
                        pwm_out      = sspc_pkg::PWM_OFF_VALUE;
                    end else begin
                        dir_lvl_next = (dir_reg != sspc_pkg::DIR_CW);
                        speed_next   = map_speed;
                        pwm_out      = map_pwm;
                    end
                end
            end
            sspc_pkg::KIND_COMPUTE: begin
                speed_next = map_speed;
                pwm_out    = map_pwm;
            end
            sspc_pkg::KIND_RAW: begin
                pwm_out = raw_sat;
            end
            default: begin
                pwm_out = '0;
            end
        endcase
        // apply the pwm value
        if ((kind_reg == sspc_pkg::KIND_RAW) ||
            ((kind_reg == sspc_pkg::KIND_SET) && !blocked_reg &&
             (dir_reg != sspc_pkg::DIR_OFF))) begin
            compare_next = sspc_pkg::PWM_PERIOD - pwm_out;
            if (pwm_out == sspc_pkg::PWM_OFF_VALUE) begin
                running_next = 1'b0;
                if (off_zero_reg) begin
                    compare_next = sspc_pkg::PWM_PERIOD;
                    enable_next  = 1'b0;
                end else begin
                    timer_next = 1'b0;
                end
            end else begin
                timer_next   = 1'b1;
                running_next = 1'b1;
                if (off_zero_reg) begin
                    enable_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        m_tdata_next = {1'b0, report, speed_next, running_next, dir_lvl_next,
                        enable_next ^ invert_en_reg, timer_next,
                        compare_next[FLD_W-1:0], pwm_out[FLD_W-1:0]};
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (apply_en) begin
            m_tvalid_next = 1'b1;
        end
    end

    // control and spindle state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sspc_pkg::S_IDLE;
            m_tvalid_reg <= 1'b0;
            compare_reg  <= sspc_pkg::PWM_PERIOD;
            timer_reg    <= 1'b0;
            enable_reg   <= 1'b0;
            dir_lvl_reg  <= 1'b0;
            running_reg  <= 1'b0;
            speed_reg    <= '0;
            rpm_min_reg  <= '0;
            rpm_max_reg  <= sspc_pkg::RPM_MAX_RESET;
            slope_reg    <= sspc_pkg::SLOPE_RESET;
            laser_reg    <= 1'b0;
            off_zero_reg <= 1'b0;
            invert_en_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (apply_en) begin
                compare_reg <= compare_next;
                timer_reg   <= timer_next;
                enable_reg  <= enable_next;
                dir_lvl_reg <= dir_lvl_next;
                running_reg <= running_next;
                speed_reg   <= speed_next;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sspc_pkg::CFG_RPM_MIN:   rpm_min_reg   <= cfg_data[RPM_W-1:0];
                    sspc_pkg::CFG_RPM_MAX:   rpm_max_reg   <= cfg_data[RPM_W-1:0];
                    sspc_pkg::CFG_SLOPE:     slope_reg     <= cfg_data;
                    sspc_pkg::CFG_LASER:     laser_reg     <= cfg_data[0];
                    sspc_pkg::CFG_OFF_ZERO:  off_zero_reg  <= cfg_data[0];
                    sspc_pkg::CFG_INVERT_EN: invert_en_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_hs) begin
            kind_reg    <= s_tuser;
            dir_reg     <= s_tdata[1:0];
            rpm_reg     <= laser_zero ? '0 : s_tdata[21:2];
            ovr_reg     <= s_tdata[29:22];
            raw_reg     <= s_tdata[36:30];
            blocked_reg <= s_tdata[37];
        end
        if (load_prod) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (load_scaled) begin
            scaled_reg <= prod_reg[RS+SC_W-1:RS];
        end
        if (apply_en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule
`default_nettype wire

[tb/sv/tb_spindle_speed_pwm_control.sv]
// Self-checking testbench for spindle_speed_pwm_control: stream driver, monitor and predictor.
module tb_spindle_speed_pwm_control;

    localparam int KIND_W = sspc_pkg::KIND_W;
    localparam int DIR_W  = sspc_pkg::DIR_W;
    localparam int RPM_W  = sspc_pkg::RPM_W;
    localparam int OVR_W  = sspc_pkg::OVR_W;
    localparam int RAW_W  = sspc_pkg::RAW_W;
    localparam int FLD_W  = sspc_pkg::FLD_W;
    localparam int PWM_W  = sspc_pkg::PWM_W;
    localparam int SLOPE_W = sspc_pkg::SLOPE_W;
    localparam int CIDX_W = sspc_pkg::CIDX_W;
    localparam int CDAT_W = sspc_pkg::CDAT_W;

    localparam logic [KIND_W-1:0] KIND_NOP    = 2'd3;
    localparam logic [DIR_W-1:0]  DIR_CCW     = 2'd2;
    localparam logic [DIR_W-1:0]  DIR_CCW_ALT = 2'd3;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 145;
    localparam int HOLD_AT         = 500;
    localparam int HOLD_CYCLES     = 150;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [1:0]        pad;
        logic              blocked;
        logic [RAW_W-1:0]  raw;
        logic [OVR_W-1:0]  ovr;
        logic [RPM_W-1:0]  rpm;
        logic [DIR_W-1:0]  dir;
    } spindle_cmd_t;

    typedef struct packed {
        logic              pad;
        logic              report;
        logic [RPM_W-1:0]  speed;
        logic              on;
        logic              dir_pin;
        logic              en_pin;
        logic              timer;
        logic [FLD_W-1:0]  compare;
        logic [FLD_W-1:0]  pwm;
    } spindle_status_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [sspc_pkg::S_DATA_W-1:0] s_tdata   = '0;
    logic [KIND_W-1:0]             s_tuser   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [sspc_pkg::M_DATA_W-1:0] m_tdata;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CIDX_W-1:0]             cfg_index = '0;
    logic [CDAT_W-1:0]             cfg_data  = '0;

    // predictor configuration and spindle state
    logic [RPM_W-1:0]   lim_rpm_min       = '0;
    logic [RPM_W-1:0]   lim_rpm_max       = sspc_pkg::RPM_MAX_RESET;
    logic [SLOPE_W-1:0] slope_cfg         = sspc_pkg::SLOPE_RESET;
    logic               laser_on          = 1'b0;
    logic               stop_at_off       = 1'b0;
    logic               enable_active_low = 1'b0;
    logic [PWM_W-1:0]   cmp_level         = sspc_pkg::PWM_PERIOD;
    logic               timer_bit         = 1'b0;
    logic               enable_bit        = 1'b0;
    logic               dir_bit           = 1'b0;
    logic               run_bit           = 1'b0;
    logic [RPM_W-1:0]   speed_q           = '0;

    spindle_cmd_t    command_backlog[$];
    spindle_status_t awaited_status[$];
    spindle_cmd_t    offered_cmd;
    logic            no_gaps      = 1'b0;
    int              hold_left    = 0;
    logic            held_off     = 1'b0;
    int              results_seen = 0;
    int              error_count  = 0;
    int              settings_used = 0;
    int              kind_count[4] = '{0, 0, 0, 0};

    spindle_speed_pwm_control DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    task automatic halt_spindle();
        cmp_level  = sspc_pkg::PWM_PERIOD;
        run_bit    = 1'b0;
        enable_bit = 1'b0;
    endtask

    function automatic logic [PWM_W-1:0] map_speed_to_duty(input logic [RPM_W-1:0] rpm,
                                                           input logic [OVR_W-1:0] ovr);
        logic [63:0] scaled;
        logic [63:0] duty;
        scaled = (64'(rpm) * 64'(ovr)) / 64'd100;
        if (lim_rpm_min >= lim_rpm_max || scaled >= 64'(lim_rpm_max)) begin
            speed_q = lim_rpm_max;
            return sspc_pkg::PWM_MAX_VALUE;
        end
        if (scaled <= 64'(lim_rpm_min)) begin
            speed_q = (scaled == 0) ? '0 : lim_rpm_min;
            return (scaled == 0) ? sspc_pkg::PWM_OFF_VALUE : sspc_pkg::PWM_MIN_VALUE;
        end
        speed_q = scaled[RPM_W-1:0];
        duty = (((scaled - 64'(lim_rpm_min)) * 64'(slope_cfg)) >> sspc_pkg::SLOPE_SHIFT)
               + 64'(sspc_pkg::PWM_MIN_VALUE);
        return (duty > 64'(sspc_pkg::PWM_MAX_VALUE)) ? sspc_pkg::PWM_MAX_VALUE
                                                     : duty[PWM_W-1:0];
    endfunction

    task automatic apply_duty(input logic [PWM_W-1:0] p);
        cmp_level = sspc_pkg::PWM_PERIOD - p;
        if (p == sspc_pkg::PWM_OFF_VALUE) begin
            if (stop_at_off) begin
                halt_spindle();
            end else begin
                timer_bit = 1'b0;
                run_bit   = 1'b0;
            end
        end else begin
            timer_bit = 1'b1;
            run_bit   = 1'b1;
            if (stop_at_off)
                enable_bit = 1'b1;
        end
    endtask

    task automatic predict_spindle_status(input spindle_cmd_t c);
        spindle_status_t due;
        logic [PWM_W-1:0] duty;
        logic [RPM_W-1:0] rpm;
        due  = '0;
        duty = '0;
        rpm  = c.rpm;
        case (c.kind)
            sspc_pkg::KIND_SET: begin
                if (!c.blocked) begin
                    if (c.dir == sspc_pkg::DIR_OFF) begin
                        speed_q = '0;
                        halt_spindle();
                        duty = sspc_pkg::PWM_OFF_VALUE;
                    end else begin
                        dir_bit = (c.dir != sspc_pkg::DIR_CW);
                        if (laser_on && dir_bit)
                            rpm = '0;
                        duty = map_speed_to_duty(rpm, c.ovr);
                        apply_duty(duty);
                    end
                    due.report = 1'b1;
                end
            end
            sspc_pkg::KIND_COMPUTE: begin
                duty = map_speed_to_duty(c.rpm, c.ovr);
            end
            sspc_pkg::KIND_RAW: begin
                duty = ({1'b0, c.raw} > sspc_pkg::PWM_PERIOD) ? sspc_pkg::PWM_PERIOD
                                                             : {1'b0, c.raw};
                apply_duty(duty);
            end
            default: ;
        endcase
        due.pwm     = duty[FLD_W-1:0];
        due.compare = cmp_level[FLD_W-1:0];
        due.timer   = timer_bit;
        due.en_pin  = enable_bit ^ enable_active_low;
        due.dir_pin = dir_bit;
        due.on      = run_bit;
        due.speed   = speed_q;
        awaited_status.push_back(due);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_spindle_status(offered_cmd);
                kind_count[offered_cmd.kind]++;
            end
            if (!s_tvalid || s_tready) begin
                if (command_backlog.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 7)) begin
                    offered_cmd = command_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= offered_cmd[sspc_pkg::S_DATA_W-1:0];
                    s_tuser  <= offered_cmd.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with one long hold-off to back up the input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!held_off && results_seen >= HOLD_AT) begin
            held_off  <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= no_gaps || ($urandom_range(0, 99) >= 7);
        end
    end

    // monitor
    always @(posedge aclk) begin : monitor
        spindle_status_t got;
        spindle_status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            results_seen++;
            if (awaited_status.size() == 0) begin
                error_count++;
                $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
            end else begin
                want = awaited_status.pop_front();
                check_field("duty", 32'(want.pwm), 32'(got.pwm));
                check_field("compare_level", 32'(want.compare), 32'(got.compare));
                check_field("timer_running", 32'(want.timer), 32'(got.timer));
                check_field("enable_pin", 32'(want.en_pin), 32'(got.en_pin));
                check_field("direction_pin", 32'(want.dir_pin), 32'(got.dir_pin));
                check_field("spindle_on", 32'(want.on), 32'(got.on));
                check_field("effective_speed", 32'(want.speed), 32'(got.speed));
                check_field("report_now", 32'(want.report), 32'(got.report));
                check_field("padding", 32'(want.pad), 32'(got.pad));
            end
        end
    end

    task automatic queue_command(input logic [KIND_W-1:0] kind, input logic [DIR_W-1:0] dir,
                                 input logic [RPM_W-1:0] rpm, input logic [OVR_W-1:0] ovr,
                                 input logic [RAW_W-1:0] raw, input logic blocked);
        spindle_cmd_t c;
        c = '0;
        c.kind    = kind;
        c.dir     = dir;
        c.rpm     = rpm;
        c.ovr     = ovr;
        c.raw     = raw;
        c.blocked = blocked;
        command_backlog.push_back(c);
    endtask

    task automatic write_register(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            sspc_pkg::CFG_RPM_MIN:   lim_rpm_min       = value[RPM_W-1:0];
            sspc_pkg::CFG_RPM_MAX:   lim_rpm_max       = value[RPM_W-1:0];
            sspc_pkg::CFG_SLOPE:     slope_cfg         = value;
            sspc_pkg::CFG_LASER:     laser_on          = value[0];
            sspc_pkg::CFG_OFF_ZERO:  stop_at_off       = value[0];
            sspc_pkg::CFG_INVERT_EN: enable_active_low = value[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [RPM_W-1:0] lo, input logic [RPM_W-1:0] hi,
                             input logic [SLOPE_W-1:0] slope, input logic laser,
                             input logic off_zero, input logic inv_en);
        write_register(sspc_pkg::CFG_RPM_MIN, CDAT_W'(lo));
        write_register(sspc_pkg::CFG_RPM_MAX, CDAT_W'(hi));
        write_register(sspc_pkg::CFG_SLOPE, slope);
        write_register(sspc_pkg::CFG_LASER, CDAT_W'(laser));
        write_register(sspc_pkg::CFG_OFF_ZERO, CDAT_W'(off_zero));
        write_register(sspc_pkg::CFG_INVERT_EN, CDAT_W'(inv_en));
        settings_used++;
        @(negedge aclk);
    endtask

    // slope that spans the pwm range across [lo, hi]
    function automatic logic [SLOPE_W-1:0] slope_for(input int unsigned lo, input int unsigned hi);
        logic [63:0] q;
        if (hi <= lo)
            return '1;
        q = (64'(sspc_pkg::PWM_MAX_VALUE - sspc_pkg::PWM_MIN_VALUE) << sspc_pkg::SLOPE_SHIFT)
            / 64'(hi - lo);
        return (q > 64'(32'hFFFF_FFFF)) ? '1 : q[SLOPE_W-1:0];
    endfunction

    task automatic wait_until_idle();
        do @(negedge aclk);
        while (command_backlog.size() != 0 || s_tvalid || awaited_status.size() != 0);
        repeat (2) @(posedge aclk);
    endtask

    initial begin
        int pick;
        int v;
        int unsigned lo;
        int unsigned hi;
        int unsigned top;
        logic [KIND_W-1:0] kind;
        logic [DIR_W-1:0]  dir;
        logic [RPM_W-1:0]  rpm;
        logic [OVR_W-1:0]  ovr;
        logic [RAW_W-1:0]  raw;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, reset configuration
        queue_command(sspc_pkg::KIND_COMPUTE, sspc_pkg::DIR_OFF, 0, 100, 0, 1'b0);
        queue_command(sspc_pkg::KIND_SET, sspc_pkg::DIR_CW, 8000, 100, 0, 1'b0);
        queue_command(sspc_pkg::KIND_SET, DIR_CCW, 20'hFFFFF, 200, 0, 1'b0);
        queue_command(sspc_pkg::KIND_SET, sspc_pkg::DIR_CW, 1, 10, 0, 1'b0);
        queue_command(sspc_pkg::KIND_SET, DIR_CCW_ALT, 4000, 150, 0, 1'b0);
        queue_command(sspc_pkg::KIND_SET, sspc_pkg::DIR_OFF, 9000, 100, 0, 1'b0);
        queue_command(sspc_pkg::KIND_SET, sspc_pkg::DIR_CW, 9000, 100, 0, 1'b1);
        queue_command(sspc_pkg::KIND_RAW, sspc_pkg::DIR_OFF, 0, 0, 127, 1'b0);
        queue_command(sspc_pkg::KIND_RAW, sspc_pkg::DIR_OFF, 0, 0, 0, 1'b0);
        queue_command(sspc_pkg::KIND_RAW, sspc_pkg::DIR_OFF, 0, 0, 100, 1'b0);
        queue_command(sspc_pkg::KIND_RAW, sspc_pkg::DIR_OFF, 0, 0, 1, 1'b0);
        queue_command(KIND_NOP, DIR_CCW_ALT, 20'hFFFFF, 255, 127, 1'b1);
        queue_command(sspc_pkg::KIND_SET, sspc_pkg::DIR_CW, 5000, 0, 0, 1'b0);
        queue_command(sspc_pkg::KIND_SET, sspc_pkg::DIR_CW, 5000, 255, 0, 1'b0);
        queue_command(sspc_pkg::KIND_COMPUTE, sspc_pkg::DIR_CW, 12345, 73, 0, 1'b0);
        queue_command(sspc_pkg::KIND_SET, sspc_pkg::DIR_CW, 16000, 100, 0, 1'b0);
        queue_command(sspc_pkg::KIND_SET, sspc_pkg::DIR_CW, 15999, 100, 0, 1'b0);
        wait_until_idle();

        // laser, stop on off value, inverted enable, raised minimum
        configure(1600, 16000, slope_for(1600, 16000), 1'b1, 1'b1, 1'b1);
        queue_command(sspc_pkg::KIND_SET, DIR_CCW, 8000, 100, 0, 1'b0);
        queue_command(sspc_pkg::KIND_SET, sspc_pkg::DIR_CW, 100, 100, 0, 1'b0);
        queue_command(sspc_pkg::KIND_RAW, sspc_pkg::DIR_OFF, 0, 0, 0, 1'b0);
        queue_command(sspc_pkg::KIND_RAW, sspc_pkg::DIR_OFF, 0, 0, 50, 1'b0);
        queue_command(sspc_pkg::KIND_SET, sspc_pkg::DIR_CW, 1600, 100, 0, 1'b0);
        queue_command(sspc_pkg::KIND_SET, DIR_CCW_ALT, 3000, 100, 0, 1'b0);
        wait_until_idle();

        // empty speed span
        configure(5000, 5000, sspc_pkg::SLOPE_RESET, 1'b0, 1'b0, 1'b0);
        queue_command(sspc_pkg::KIND_SET, sspc_pkg::DIR_CW, 0, 100, 0, 1'b0);
        queue_command(sspc_pkg::KIND_COMPUTE, sspc_pkg::DIR_OFF, 0, 10, 0, 1'b0);
        wait_until_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: configure(0, 16000, slope_for(0, 16000), 1'b0, 1'b0, 1'b0);
                1: configure(0, 20'hFFFFF, slope_for(0, 20'hFFFFF), 1'b1, 1'b0, 1'b1);
                2: begin
                    no_gaps = 1'b1;
                    configure(800, 24000, slope_for(800, 24000), 1'b0, 1'b1, 1'b0);
                end
                3: configure(5000, 5000, $urandom, 1'b1, 1'b1, 1'b1);
                4: configure(0, 16000, '1, 1'b0, 1'b0, 1'b1);
                5: configure(20'hFFFFF, 0, '0, 1'b0, 1'b1, 1'b0);
                6: configure(1, 2, '1, 1'b1, 1'b0, 1'b0);
                7: configure(0, 16000, '0, 1'b0, 1'b1, 1'b1);
                default: begin
                    lo = $urandom_range(0, 40000);
                    hi = lo + $urandom_range(1, 200000);
                    configure(RPM_W'(lo), RPM_W'(hi), slope_for(lo, hi),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end
            endcase
            top = (lim_rpm_max > lim_rpm_min) ? lim_rpm_max : lim_rpm_min;
            top = top + top / 4 + 1;
            if (top > 20'hFFFFF)
                top = 20'hFFFFF;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                kind = (pick < 70) ? sspc_pkg::KIND_SET : (pick < 82) ? sspc_pkg::KIND_COMPUTE :
                       (pick < 95) ? sspc_pkg::KIND_RAW : KIND_NOP;
                pick = $urandom_range(0, 99);
                dir  = (pick < 10) ? sspc_pkg::DIR_OFF : (pick < 55) ? sspc_pkg::DIR_CW :
                       (pick < 90) ? DIR_CCW : DIR_CCW_ALT;
                pick = $urandom_range(0, 99);
                ovr  = OVR_W'((pick < 85) ? $urandom_range(10, 200) :
                              (pick < 95) ? 100 : $urandom_range(0, 255));
                pick = $urandom_range(0, 9);
                case (pick)
                    0: rpm = RPM_W'($urandom);
                    1: rpm = RPM_W'($urandom_range(0, 15));
                    2, 3: begin
                        v = int'(pick == 2 ? lim_rpm_min : lim_rpm_max)
                            + int'($urandom_range(0, 40)) - 20;
                        if (v < 0)
                            v = 0;
                        if (v > 20'hFFFFF)
                            v = 20'hFFFFF;
                        rpm = RPM_W'(v);
                        ovr = 100;
                    end
                    default: rpm = RPM_W'($urandom_range(0, top));
                endcase
                raw = RAW_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                         : $urandom_range(0, 100));
                queue_command(kind, dir, rpm, ovr, raw, $urandom_range(0, 99) < 8);
            end
            wait_until_idle();
            no_gaps = 1'b0;
        end

        repeat (10) @(posedge aclk);
        if (awaited_status.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected transactions never arrived", $time, awaited_status.size());
        end
        $display("Covered %0d set-state, %0d compute, %0d raw and %0d idle-code commands",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
        $display("over %0d register settings; %0d results checked, %0d mismatches",
                 settings_used, results_seen, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("%0t: timeout, %0d transactions outstanding", $time, awaited_status.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
